>>> sv/cerc_pkg.sv
// ----------------------------------------------------------------------------
// cerc_pkg: shared types and constants for the exit-reach and cycle checker
// Field types of the request and response items, instruction and verdict
// codes, state machine types and the status bundle of the graph walker.
// ----------------------------------------------------------------------------
package cerc_pkg;

   // Default number of instructions held for one program.
   localparam int unsigned MAX_INSTR_DEF = 1024;

   // Fixed field widths of the items.
   localparam int unsigned KIND_W    = 2;
   localparam int unsigned TARGET_W  = 11;
   localparam int unsigned VERDICT_W = 2;

   typedef logic [KIND_W-1:0]    kind_type;
   typedef logic [TARGET_W-1:0]  target_type;
   typedef logic [VERDICT_W-1:0] verdict_type;

   // Instruction kinds. The fourth code adds no edges.
   localparam kind_type KIND_ADVANCE = 2'd0;
   localparam kind_type KIND_JUMP    = 2'd1;
   localparam kind_type KIND_COND    = 2'd2;

   // Verdict codes.
   localparam verdict_type VERDICT_NEVER     = 2'd0;
   localparam verdict_type VERDICT_SOMETIMES = 2'd1;
   localparam verdict_type VERDICT_ALWAYS    = 2'd2;
   localparam verdict_type VERDICT_INVALID   = 2'd3;

   // One stored instruction.
   typedef struct packed {
      kind_type   kind;
      target_type target;
   } instr_type;

   // Status reported by the walker to the top level.
   typedef struct packed {
      logic done;
      logic reached_exit;
      logic found_cycle;
   } walk_sts_type;

   // Top level sequencer.
   typedef enum logic [1:0] {
      ST_LOAD,
      ST_CHECK,
      ST_WALK,
      ST_DONE
   } top_state_type;

   // Walker sequencer.
   typedef enum logic [2:0] {
      W_IDLE,
      W_CLEAR,
      W_FETCH,
      W_EDGE,
      W_MARK,
      W_POP,
      W_END
   } walk_state_type;

endpackage

>>> sv/cerc_ifs.sv
// ----------------------------------------------------------------------------
// cerc_ifs: item channels of the exit-reach and cycle checker
// Valid/ready channels for instruction items and verdict items.
// ----------------------------------------------------------------------------
interface cerc_req_if;
   import cerc_pkg::*;

   logic       valid;
   logic       ready;
   kind_type   kind;
   target_type target;
   logic       is_last;

   modport source (output valid, output kind, output target, output is_last, input ready);
   modport sink   (input valid, input kind, input target, input is_last, output ready);
endinterface

interface cerc_rsp_if;
   import cerc_pkg::*;

   logic        valid;
   logic        ready;
   verdict_type verdict;

   modport source (output valid, output verdict, input ready);
   modport sink   (input valid, input verdict, output ready);
endinterface

>>> sv/cerc_walker.sv
// ----------------------------------------------------------------------------
// cerc_walker: depth-first walk over the control-flow graph
// Clears the node marks, then walks from node 0 with an explicit stack,
// one edge at a time, and reports whether the exit was reached and whether
// a cycle was seen on the current path.
// ----------------------------------------------------------------------------
module cerc_walker #(
   parameter  int unsigned MAX_INSTR = cerc_pkg::MAX_INSTR_DEF,
   localparam int unsigned NW = $clog2(MAX_INSTR + 1),
   localparam int unsigned AW = $clog2(MAX_INSTR)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [NW-1:0]         len,
   output logic                  ir_re,
   output logic [AW-1:0]         ir_addr,
   input  cerc_pkg::instr_type   ir_data,
   output cerc_pkg::walk_sts_type sts
);
   import cerc_pkg::*;

   // Width that holds both node numbers and jump targets.
   localparam int unsigned VW = (NW > TARGET_W) ? NW : TARGET_W;

   walk_state_type state_ff, state_in;

   logic [NW-1:0] clr_idx_ff, clr_idx_in;
   logic [NW-1:0] top_node_ff, top_node_in;
   logic [1:0]    top_edge_ff, top_edge_in;
   logic [NW-1:0] sp_ff, sp_in;
   logic [NW-1:0] v_ff, v_in;
   logic          reached_ff, reached_in;
   logic          cycle_ff, cycle_in;

   // Mark memory: bit 1 visited, bit 0 on the current path.
   logic [1:0]    mark_mem [0:MAX_INSTR];
   logic [1:0]    mark_rd_q;
   logic          mk_we, mk_re;
   logic [NW-1:0] mk_waddr, mk_raddr;
   logic [1:0]    mk_wdata;

   // Stack of the entries below the top: node and next edge index.
   logic [NW+1:0] stk_mem [0:MAX_INSTR-1];
   logic [NW+1:0] stk_rd_q;
   logic          sk_we, sk_re;
   logic [AW-1:0] sk_waddr, sk_raddr;
   logic [NW+1:0] sk_wdata;

   // Successor of the top node for its current edge index.
   logic [VW-1:0] u_wide, len_wide, succ_wide;
   logic          succ_ok;
   logic [NW-1:0] sp_dec;

   always_comb begin
      u_wide    = VW'(top_node_ff);
      len_wide  = VW'(len);
      succ_wide = '0;
      succ_ok   = 1'b0;
      if (top_node_ff < len) begin
         case (ir_data.kind)
            KIND_ADVANCE: begin
               succ_wide = u_wide + VW'(1);
               succ_ok   = (top_edge_ff == 2'd0);
            end
            KIND_JUMP: begin
               succ_wide = VW'(ir_data.target) - VW'(1);
               succ_ok   = (top_edge_ff == 2'd0);
            end
            KIND_COND: begin
               succ_wide = (top_edge_ff == 2'd0) ? u_wide + VW'(1)
                                                 : VW'(ir_data.target) - VW'(1);
               succ_ok   = (top_edge_ff == 2'd0) || (top_edge_ff == 2'd1);
            end
            default: begin
               succ_ok = 1'b0;
            end
         endcase
      end
      // A destination past the exit is no edge.
      if (succ_wide > len_wide) begin
         succ_ok = 1'b0;
      end
   end

   assign sp_dec = sp_ff - NW'(1);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         W_IDLE: begin
            if (start) begin
               state_in = W_CLEAR;
            end
         end
         W_CLEAR: begin
            if (clr_idx_ff == len) begin
               state_in = W_FETCH;
            end
         end
         W_FETCH: begin
            state_in = W_EDGE;
         end
         W_EDGE: begin
            if (top_edge_ff >= 2'd2) begin
               state_in = (sp_ff == '0) ? W_END : W_POP;
            end else if (succ_ok) begin
               state_in = W_MARK;
            end
         end
         W_MARK: begin
            state_in = (!mark_rd_q[1]) ? W_FETCH : W_EDGE;
         end
         W_POP: begin
            state_in = W_FETCH;
         end
         W_END: begin
            state_in = W_IDLE;
         end
         default: begin
            state_in = W_IDLE;
         end
      endcase
   end

   // Datapath and memory controls.
   always_comb begin
      clr_idx_in  = clr_idx_ff;
      top_node_in = top_node_ff;
      top_edge_in = top_edge_ff;
      sp_in       = sp_ff;
      v_in        = v_ff;
      reached_in  = reached_ff;
      cycle_in    = cycle_ff;
      mk_we       = 1'b0;
      mk_waddr    = top_node_ff;
      mk_wdata    = 2'b00;
      mk_re       = 1'b0;
      mk_raddr    = succ_wide[NW-1:0];
      sk_we       = 1'b0;
      sk_waddr    = sp_ff[AW-1:0];
      sk_wdata    = {top_node_ff, top_edge_ff};
      sk_re       = 1'b0;
      sk_raddr    = sp_dec[AW-1:0];
      ir_re       = 1'b0;
      ir_addr     = top_node_ff[AW-1:0];
      sts         = '0;
      case (state_ff)
         W_IDLE: begin
            clr_idx_in = '0;
            reached_in = 1'b0;
            cycle_in   = 1'b0;
         end
         W_CLEAR: begin
            // Node 0 comes out of the sweep already pushed.
            mk_we       = 1'b1;
            mk_waddr    = clr_idx_ff;
            mk_wdata    = (clr_idx_ff == '0) ? 2'b11 : 2'b00;
            clr_idx_in  = clr_idx_ff + NW'(1);
            top_node_in = '0;
            top_edge_in = 2'd0;
            sp_in       = '0;
         end
         W_FETCH: begin
            ir_re = 1'b1;
         end
         W_EDGE: begin
            if (top_edge_ff >= 2'd2) begin
               // All edges done: leave the path and pop if the stack is not empty.
               mk_we    = 1'b1;
               mk_wdata = 2'b10;
               if (sp_ff != '0) begin
                  sk_re = 1'b1;
                  sp_in = sp_dec;
               end
            end else begin
               top_edge_in = top_edge_ff + 2'd1;
               if (succ_ok) begin
                  mk_re = 1'b1;
                  v_in  = succ_wide[NW-1:0];
               end
            end
         end
         W_MARK: begin
            if (!mark_rd_q[1]) begin
               // Unvisited successor: push it.
               sk_we       = 1'b1;
               sp_in       = sp_ff + NW'(1);
               mk_we       = 1'b1;
               mk_waddr    = v_ff;
               mk_wdata    = 2'b11;
               top_node_in = v_ff;
               top_edge_in = 2'd0;
               if (v_ff == len) begin
                  reached_in = 1'b1;
               end
            end else if (mark_rd_q[0]) begin
               cycle_in = 1'b1;
            end
         end
         W_POP: begin
            top_node_in = stk_rd_q[NW+1:2];
            top_edge_in = stk_rd_q[1:0];
         end
         W_END: begin
            sts.done         = 1'b1;
            sts.reached_exit = reached_ff;
            sts.found_cycle  = cycle_ff;
         end
         default: begin
            sts = '0;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= W_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      clr_idx_ff  <= clr_idx_in;
      top_node_ff <= top_node_in;
      top_edge_ff <= top_edge_in;
      sp_ff       <= sp_in;
      v_ff        <= v_in;
      reached_ff  <= reached_in;
      cycle_ff    <= cycle_in;
   end

   // Mark memory.
   always_ff @(posedge clock) begin
      if (mk_we) begin
         mark_mem[mk_waddr] <= mk_wdata;
      end
      if (mk_re) begin
         mark_rd_q <= mark_mem[mk_raddr];
      end
   end

   // Stack memory.
   always_ff @(posedge clock) begin
      if (sk_we) begin
         stk_mem[sk_waddr] <= sk_wdata;
      end
      if (sk_re) begin
         stk_rd_q <= stk_mem[sk_raddr];
      end
   end

endmodule

>>> sv/cfg_exit_reach_cycle_check_core.sv
// Flow: one instruction item per cycle while loading; the last item starts a
// check of the jump targets, a sweep over the L+1 node marks and a depth-first
// walk over the reachable nodes.
// Throughput: one program at a time; after the walk ends, or after the check
// for an invalid jump target, the verdict is registered once the slot is free.
// Reset: synchronous, clears the sequencers, the count and the result slot.
// ----------------------------------------------------------------------------
// cfg_exit_reach_cycle_check_core: exit reachability and cycle checker
// Stores a program one instruction per item, checks its jump targets and
// runs a depth-first walk to return one verdict per program.
// ----------------------------------------------------------------------------
module cfg_exit_reach_cycle_check_core #(
   parameter  int unsigned MAX_INSTR = cerc_pkg::MAX_INSTR_DEF
) (
   input  logic       clock,
   input  logic       reset,
   cerc_req_if.sink   req_if,
   cerc_rsp_if.source rsp_if
);
   import cerc_pkg::*;

   localparam int unsigned NW = $clog2(MAX_INSTR + 1);
   localparam int unsigned AW = $clog2(MAX_INSTR);
   localparam int unsigned CW = ((NW > TARGET_W) ? NW : TARGET_W) + 1;

   top_state_type state_ff, state_in;

   logic [NW-1:0] prog_cnt_ff, prog_cnt_in;
   logic          zero_tgt_ff, zero_tgt_in;
   target_type    max_tgt_ff, max_tgt_in;
   verdict_type   verdict_ff, verdict_in;
   logic          rsp_valid_ff, rsp_valid_in;
   verdict_type   rsp_verdict_ff, rsp_verdict_in;

   logic          accept, store, slot_free, bad, walk_start;
   logic          ir_re;
   logic [AW-1:0] ir_addr;
   instr_type     ir_q;
   walk_sts_type  wk_sts;

   // Instruction memory.
   instr_type     imem [0:MAX_INSTR-1];

   assign req_if.ready   = (state_ff == ST_LOAD);
   assign accept         = req_if.valid && req_if.ready;
   assign store          = accept && (prog_cnt_ff < NW'(MAX_INSTR));
   assign slot_free      = !rsp_valid_ff || rsp_if.ready;
   assign bad            = zero_tgt_ff || (CW'(max_tgt_ff) > CW'(prog_cnt_ff) + CW'(1));
   assign walk_start     = (state_ff == ST_CHECK) && !bad;
   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.verdict = rsp_verdict_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (accept && req_if.is_last) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = bad ? ST_DONE : ST_WALK;
         end
         ST_WALK: begin
            if (wk_sts.done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // Program bookkeeping and the result slot.
   always_comb begin
      prog_cnt_in    = prog_cnt_ff;
      zero_tgt_in    = zero_tgt_ff;
      max_tgt_in     = max_tgt_ff;
      verdict_in     = verdict_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_if.ready;
      rsp_verdict_in = rsp_verdict_ff;
      case (state_ff)
         ST_LOAD: begin
            if (store) begin
               prog_cnt_in = prog_cnt_ff + NW'(1);
               if ((req_if.kind == KIND_JUMP) || (req_if.kind == KIND_COND)) begin
                  if (req_if.target == '0) begin
                     zero_tgt_in = 1'b1;
                  end
                  if (req_if.target > max_tgt_ff) begin
                     max_tgt_in = req_if.target;
                  end
               end
            end
         end
         ST_CHECK: begin
            verdict_in = VERDICT_INVALID;
         end
         ST_WALK: begin
            if (!wk_sts.reached_exit) begin
               verdict_in = VERDICT_NEVER;
            end else if (wk_sts.found_cycle) begin
               verdict_in = VERDICT_SOMETIMES;
            end else begin
               verdict_in = VERDICT_ALWAYS;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               rsp_valid_in   = 1'b1;
               rsp_verdict_in = verdict_ff;
               prog_cnt_in    = '0;
               zero_tgt_in    = 1'b0;
               max_tgt_in     = '0;
            end
         end
         default: begin
            verdict_in = verdict_ff;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         prog_cnt_ff  <= '0;
         zero_tgt_ff  <= 1'b0;
         max_tgt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prog_cnt_ff  <= prog_cnt_in;
         zero_tgt_ff  <= zero_tgt_in;
         max_tgt_ff   <= max_tgt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      verdict_ff     <= verdict_in;
      rsp_verdict_ff <= rsp_verdict_in;
   end

   // Instruction memory: written while loading, read by the walker.
   always_ff @(posedge clock) begin
      if (store) begin
         imem[prog_cnt_ff[AW-1:0]] <= '{kind: req_if.kind, target: req_if.target};
      end
      if (ir_re) begin
         ir_q <= imem[ir_addr];
      end
   end

   cerc_walker #(
      .MAX_INSTR (MAX_INSTR)
   ) u_walker (
      .clock   (clock),
      .reset   (reset),
      .start   (walk_start),
      .len     (prog_cnt_ff),
      .ir_re   (ir_re),
      .ir_addr (ir_addr),
      .ir_data (ir_q),
      .sts     (wk_sts)
   );

`ifndef SYNTHESIS
   // A new verdict appears only out of the result state.
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("verdict raised outside the result state");

   // The walker finishes only while the top level waits for it.
   a_walk_owned: assert property (@(posedge clock) disable iff (reset)
      wk_sts.done |-> (state_ff == ST_WALK))
      else $error("walker finished while not walking");

   // A delivered verdict leaves the program count empty.
   a_count_cleared: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> (prog_cnt_ff == '0))
      else $error("program count not cleared with the verdict");

   // The stored count never passes the capacity.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      prog_cnt_ff <= NW'(MAX_INSTR))
      else $error("program count beyond capacity");
`endif

endmodule
